// ===== rtl/tcprx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP receive state machine package
// Shared codes, flag masks and the result word layout.
// ----------------------------------------------------------------------------
package tcprx_pkg;

   // Default number of entries in the sent-segment end queue.
   localparam int SENT_QUEUE_DEPTH_DEFAULT = 16;

   // Operation codes of the request word.
   localparam logic [1:0] OP_RECV  = 2'd0;
   localparam logic [1:0] OP_SENT  = 2'd1;
   localparam logic [1:0] OP_FORCE = 2'd2;

   // Connection state codes.
   localparam logic [3:0] CS_LISTEN     = 4'd0;
   localparam logic [3:0] CS_SYN_SENT   = 4'd1;
   localparam logic [3:0] CS_SYN_RCVD   = 4'd2;
   localparam logic [3:0] CS_ESTAB      = 4'd3;
   localparam logic [3:0] CS_FW1        = 4'd4;
   localparam logic [3:0] CS_FW2        = 4'd5;
   localparam logic [3:0] CS_CLOSE_WAIT = 4'd6;
   localparam logic [3:0] CS_LAST_ACK   = 4'd7;
   localparam logic [3:0] CS_CLOSED     = 4'd8;
   localparam logic [3:0] CS_TERMINATED = 4'd9;
   localparam logic [3:0] CS_FREED      = 4'd10;

   // TCP flag bits.
   localparam int FL_FIN_BIT = 0;
   localparam int FL_SYN_BIT = 1;
   localparam int FL_RST_BIT = 2;
   localparam int FL_ACK_BIT = 4;
   localparam logic [5:0] FL_SYN     = 6'd2;
   localparam logic [5:0] FL_ACK     = 6'd16;
   localparam logic [5:0] FL_SYN_ACK = 6'd18;

   // Drop codes.
   localparam logic [3:0] DROP_OK          = 4'd0;
   localparam logic [3:0] DROP_BAD_STATE   = 4'd1;
   localparam logic [3:0] DROP_NOT_SYN     = 4'd2;
   localparam logic [3:0] DROP_SS_FLAGS    = 4'd3;
   localparam logic [3:0] DROP_SYNACK_ACK  = 4'd4;
   localparam logic [3:0] DROP_NO_ACK      = 4'd5;
   localparam logic [3:0] DROP_WRONG_SEQ   = 4'd6;
   localparam logic [3:0] DROP_SYN_UNEXP   = 4'd7;
   localparam logic [3:0] DROP_OUT_OF_ORD  = 4'd8;
   localparam logic [3:0] DROP_UNKNOWN     = 4'd9;

   // Result word, less the retire count and the final state.
   typedef struct packed {
      logic        reply_valid;
      logic [5:0]  reply_flags;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic        deliver_payload;
      logic        wake_socket;
      logic [3:0]  drop_code;
      logic        reset_kill;
      logic        queue_full;
   } rsp_type;

endpackage

// ===== rtl/tcprx_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP receive request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface tcprx_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] seg_seq;
   logic [31:0] seg_ack;
   logic [5:0]  seg_flags;
   logic [15:0] payload_length;
   logic [31:0] local_seq;
   logic [31:0] sent_start;
   logic [15:0] sent_length;
   logic [3:0]  forced_state;

   modport source (output valid, operation, seg_seq, seg_ack, seg_flags, payload_length,
                   local_seq, sent_start, sent_length, forced_state, input ready);
   modport sink (input valid, operation, seg_seq, seg_ack, seg_flags, payload_length,
                 local_seq, sent_start, sent_length, forced_state, output ready);
endinterface

// ===== rtl/tcprx_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP receive response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface tcprx_rsp_if;
   logic        valid;
   logic        ready;
   logic        reply_valid;
   logic [5:0]  reply_flags;
   logic [31:0] reply_seq;
   logic [31:0] reply_ack;
   logic        deliver_payload;
   logic        wake_socket;
   logic [3:0]  drop_code;
   logic [4:0]  retired_count;
   logic        reset_kill;
   logic        queue_full;
   logic [3:0]  conn_state_out;

   modport source (output valid, reply_valid, reply_flags, reply_seq, reply_ack,
                   deliver_payload, wake_socket, drop_code, retired_count, reset_kill,
                   queue_full, conn_state_out, input ready);
   modport sink (input valid, reply_valid, reply_flags, reply_seq, reply_ack,
                 deliver_payload, wake_socket, drop_code, retired_count, reset_kill,
                 queue_full, conn_state_out, output ready);
endinterface

// ===== rtl/tcprx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP receive generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcprx_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcp_receive_state_machine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP receive state machine core
// Per-connection receive handling with a RAM-held queue of sent segment ends.
//
//   Channel   Dir  Carries
//   req_chan  in   operation, received header fields, sent segment, forced state
//   rsp_chan  out  reply, delivery, wake-up, drop code, retire count, state
//
// A request passes through accept, evaluate and result; a received segment
// that scans the sent queue passes through a retire step before the result.
// The scan retires one queue entry per cycle through the RAM read port.
// A new request is taken while the previous result still waits on rsp_chan.
// Reset is synchronous; queue entries need no clearing since only written
// entries are read.
// ----------------------------------------------------------------------------
module tcp_receive_state_machine_core
   import tcprx_pkg::*;
#(
   parameter int SENT_QUEUE_DEPTH = SENT_QUEUE_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   tcprx_req_if.sink   req_chan,
   tcprx_rsp_if.source rsp_chan
);

   localparam int PW = (SENT_QUEUE_DEPTH > 1) ? $clog2(SENT_QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(SENT_QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      FSM_IDLE   = 4'b0001,
      FSM_EVAL   = 4'b0010,
      FSM_RETIRE = 4'b0100,
      FSM_DONE   = 4'b1000
   } fsm_type;

   fsm_type     fsm_ff, fsm_in;
   logic [3:0]  cs_ff, cs_in;
   logic [31:0] rcv_ff, rcv_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] retired_ff, retired_in;

   // Captured request word.
   logic [1:0]  op_ff;
   logic [31:0] seq_ff, ack_ff, lseq_ff, start_ff;
   logic [5:0]  flags_ff;
   logic [15:0] plen_ff, slen_ff;
   logic [3:0]  forced_ff;

   rsp_type res_ff, res_calc;
   logic    retire_go;
   logic    q_full;

   // Output register.
   logic        rsp_valid_ff;
   rsp_type     rsp_res_ff;
   logic [4:0]  rsp_retired_ff;
   logic [3:0]  rsp_cs_ff;

   logic [32:0] rd_data;
   logic        wr_en;
   logic [32:0] wr_data;
   logic        can_retire;
   logic [CW+4:0] retired_ext;
   logic [3:0]  cs_calc;
   logic [31:0] rcv_calc;

   assign req_chan.ready = (fsm_ff == FSM_IDLE);
   assign q_full = (count_ff == CW'(SENT_QUEUE_DEPTH));
   assign wr_en = (fsm_ff == FSM_EVAL) && (op_ff == OP_SENT) && !q_full;
   assign wr_data = {1'b0, start_ff} + {17'd0, slen_ff};
   assign can_retire = (count_ff != '0) && ({1'b0, ack_ff} >= rd_data);
   assign retired_ext = {5'd0, retired_ff};

   // Queue RAM; it reads the next head so the data tracks head_ff.
   tcprx_ram #(
      .WIDTH(33),
      .DEPTH(SENT_QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_data),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   // Segment evaluation against the connection state.
   always_comb begin
      logic        fin;
      logic        fio;
      logic        run_norm;
      logic [31:0] sum;
      fin = flags_ff[FL_FIN_BIT];
      fio = (seq_ff == rcv_ff) && fin;
      run_norm = 1'b0;
      sum = rcv_ff + {16'd0, plen_ff} + {31'd0, fin};
      res_calc = '0;
      cs_calc = cs_ff;
      rcv_calc = rcv_ff;
      retire_go = 1'b0;
      unique case (op_ff)
         OP_RECV: begin
            unique case (cs_ff)
               CS_CLOSE_WAIT, CS_CLOSED, CS_TERMINATED, CS_FREED: begin
                  res_calc.drop_code = DROP_BAD_STATE;
               end
               CS_LISTEN: begin
                  if (flags_ff != FL_SYN) begin
                     res_calc.drop_code = DROP_NOT_SYN;
                  end else begin
                     rcv_calc = seq_ff + 32'd1;
                     res_calc.reply_valid = 1'b1;
                     res_calc.reply_flags = FL_SYN_ACK;
                     res_calc.reply_seq = lseq_ff - 32'd1;
                     res_calc.reply_ack = seq_ff + 32'd1;
                     cs_calc = CS_SYN_RCVD;
                  end
               end
               CS_SYN_SENT: begin
                  if (flags_ff == FL_SYN) begin
                     rcv_calc = seq_ff + 32'd1;
                     res_calc.reply_valid = 1'b1;
                     res_calc.reply_flags = FL_ACK;
                     res_calc.reply_seq = lseq_ff;
                     res_calc.reply_ack = seq_ff + 32'd1;
                     cs_calc = CS_SYN_RCVD;
                  end else if (flags_ff == FL_SYN_ACK) begin
                     if (ack_ff != lseq_ff) begin
                        res_calc.drop_code = DROP_SYNACK_ACK;
                     end else begin
                        rcv_calc = seq_ff + 32'd1;
                        res_calc.reply_valid = 1'b1;
                        res_calc.reply_flags = FL_ACK;
                        res_calc.reply_seq = lseq_ff;
                        res_calc.reply_ack = seq_ff + 32'd1;
                        cs_calc = CS_ESTAB;
                        res_calc.wake_socket = 1'b1;
                     end
                  end else begin
                     res_calc.drop_code = DROP_SS_FLAGS;
                  end
               end
               CS_SYN_RCVD: begin
                  if (flags_ff == FL_SYN) begin
                     rcv_calc = seq_ff + 32'd1;
                     res_calc.reply_valid = 1'b1;
                     res_calc.reply_flags = FL_SYN_ACK;
                     res_calc.reply_seq = lseq_ff - 32'd1;
                     res_calc.reply_ack = seq_ff + 32'd1;
                     cs_calc = CS_SYN_RCVD;
                  end else if (!flags_ff[FL_ACK_BIT] || ack_ff != lseq_ff) begin
                     res_calc.drop_code = DROP_NO_ACK;
                  end else if (seq_ff != rcv_ff) begin
                     res_calc.drop_code = DROP_WRONG_SEQ;
                  end else begin
                     cs_calc = CS_ESTAB;
                     res_calc.wake_socket = 1'b1;
                     run_norm = 1'b1;
                  end
               end
               CS_ESTAB: begin
                  if (fio) begin
                     cs_calc = CS_CLOSE_WAIT;
                     res_calc.wake_socket = 1'b1;
                  end
                  run_norm = 1'b1;
               end
               CS_FW1: begin
                  if (ack_ff == lseq_ff) begin
                     if (fio) begin
                        cs_calc = CS_TERMINATED;
                        res_calc.wake_socket = 1'b1;
                     end else begin
                        cs_calc = CS_FW2;
                     end
                  end else if (fio) begin
                     cs_calc = CS_LAST_ACK;
                     res_calc.wake_socket = 1'b1;
                  end
                  run_norm = 1'b1;
               end
               CS_FW2: begin
                  if (fio) begin
                     cs_calc = CS_TERMINATED;
                     res_calc.wake_socket = 1'b1;
                  end
                  run_norm = 1'b1;
               end
               CS_LAST_ACK: begin
                  if (ack_ff == lseq_ff) begin
                     cs_calc = CS_TERMINATED;
                     res_calc.wake_socket = 1'b1;
                  end else begin
                     run_norm = 1'b1;
                  end
               end
               default: begin
                  res_calc.drop_code = DROP_UNKNOWN;
               end
            endcase
            // Common handling for synchronized states.
            if (run_norm) begin
               if (flags_ff[FL_SYN_BIT]) begin
                  res_calc.drop_code = DROP_SYN_UNEXP;
               end else begin
                  retire_go = 1'b1;
                  if (seq_ff == rcv_ff) begin
                     res_calc.deliver_payload = (plen_ff != 16'd0);
                     rcv_calc = sum;
                     if (fin || plen_ff != 16'd0) begin
                        res_calc.reply_valid = 1'b1;
                        res_calc.reply_flags = FL_ACK;
                        res_calc.reply_seq = lseq_ff;
                        res_calc.reply_ack = sum;
                     end
                  end else begin
                     res_calc.drop_code = DROP_OUT_OF_ORD;
                  end
               end
            end
            if (flags_ff[FL_RST_BIT]) begin
               cs_calc = CS_TERMINATED;
               res_calc.reset_kill = 1'b1;
            end
         end
         OP_SENT: begin
            res_calc.queue_full = q_full;
         end
         OP_FORCE: begin
            cs_calc = forced_ff;
         end
         default: begin
         end
      endcase
   end

   // Sequencer and queue pointer next values.
   always_comb begin
      fsm_in = fsm_ff;
      cs_in = cs_ff;
      rcv_in = rcv_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      retired_in = retired_ff;
      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req_chan.valid) begin
               fsm_in = FSM_EVAL;
            end
         end
         FSM_EVAL: begin
            cs_in = cs_calc;
            rcv_in = rcv_calc;
            retired_in = '0;
            if (wr_en) begin
               tail_in = (tail_ff == PW'(SENT_QUEUE_DEPTH - 1)) ? '0 : tail_ff + PW'(1);
               count_in = count_ff + CW'(1);
            end
            fsm_in = retire_go ? FSM_RETIRE : FSM_DONE;
         end
         FSM_RETIRE: begin
            if (can_retire) begin
               head_in = (head_ff == PW'(SENT_QUEUE_DEPTH - 1)) ? '0 : head_ff + PW'(1);
               count_in = count_ff - CW'(1);
               retired_in = retired_ff + CW'(1);
            end else begin
               fsm_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               fsm_in = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_IDLE;
         cs_ff <= CS_CLOSED;
         rcv_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         retired_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         cs_ff <= cs_in;
         rcv_ff <= rcv_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         retired_ff <= retired_in;
         if (fsm_ff == FSM_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (fsm_ff == FSM_IDLE && req_chan.valid) begin
         op_ff <= req_chan.operation;
         seq_ff <= req_chan.seg_seq;
         ack_ff <= req_chan.seg_ack;
         flags_ff <= req_chan.seg_flags;
         plen_ff <= req_chan.payload_length;
         lseq_ff <= req_chan.local_seq;
         start_ff <= req_chan.sent_start;
         slen_ff <= req_chan.sent_length;
         forced_ff <= req_chan.forced_state;
      end
      if (fsm_ff == FSM_EVAL) begin
         res_ff <= res_calc;
      end
      if (fsm_ff == FSM_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_res_ff <= res_ff;
         rsp_retired_ff <= retired_ext[4:0];
         rsp_cs_ff <= cs_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.reply_valid = rsp_res_ff.reply_valid;
   assign rsp_chan.reply_flags = rsp_res_ff.reply_flags;
   assign rsp_chan.reply_seq = rsp_res_ff.reply_seq;
   assign rsp_chan.reply_ack = rsp_res_ff.reply_ack;
   assign rsp_chan.deliver_payload = rsp_res_ff.deliver_payload;
   assign rsp_chan.wake_socket = rsp_res_ff.wake_socket;
   assign rsp_chan.drop_code = rsp_res_ff.drop_code;
   assign rsp_chan.retired_count = rsp_retired_ff;
   assign rsp_chan.reset_kill = rsp_res_ff.reset_kill;
   assign rsp_chan.queue_full = rsp_res_ff.queue_full;
   assign rsp_chan.conn_state_out = rsp_cs_ff;

   // The queue fill never exceeds its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SENT_QUEUE_DEPTH))
      else $error("sent queue count above depth");

   // An accepted request is evaluated in the next cycle.
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (fsm_ff == FSM_EVAL))
      else $error("accepted request not evaluated");

   // Every head advance retires exactly one entry.
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_RETIRE && can_retire) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("head advance without count decrement");

   // A new result is only loaded from the result state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff == FSM_DONE))
      else $error("result raised outside result state");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP receive state machine testbench
// Drives received segments, sent-segment records and forced states into the
// core, predicts every result word from a behavioral copy of the connection
// state and sent queue, and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb;
   import tcprx_pkg::*;

   localparam int QDEPTH = 16;

   logic clock;
   logic reset;

   tcprx_req_if req_chan ();
   tcprx_rsp_if rsp_chan ();

   tcp_receive_state_machine_core #(.SENT_QUEUE_DEPTH(QDEPTH)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // One expected result word.
   typedef struct {
      logic        reply_valid;
      logic [5:0]  reply_flags;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic        deliver_payload;
      logic        wake_socket;
      logic [3:0]  drop_code;
      logic [4:0]  retired_count;
      logic        reset_kill;
      logic        queue_full;
      logic [3:0]  conn_state_out;
   } seg_result_type;

   // One request word.
   typedef struct {
      logic [1:0]  operation;
      logic [31:0] seg_seq;
      logic [31:0] seg_ack;
      logic [5:0]  seg_flags;
      logic [15:0] payload_length;
      logic [31:0] local_seq;
      logic [31:0] sent_start;
      logic [15:0] sent_length;
      logic [3:0]  forced_state;
   } seg_item_type;

   // Predicted connection state.
   logic [3:0]  conn_st;
   logic [31:0] rcv_nxt;
   logic [32:0] sent_ends [QDEPTH];
   int          q_head, q_tail, q_count;

   seg_result_type expected_results[$];
   int          error_count = 0;
   int          result_count = 0;
   int          item_count = 0;
   bit          no_idle = 1'b0;

   // Clock: 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Segment handling for synchronized states.
   function automatic void predict_data_segment(inout seg_result_type r,
                                                input seg_item_type it);
      int retired;
      retired = 0;
      if (it.seg_flags[FL_SYN_BIT]) begin
         r.drop_code = DROP_SYN_UNEXP;
         return;
      end
      while (q_count > 0 && {1'b0, it.seg_ack} >= sent_ends[q_head]) begin
         q_head = (q_head + 1) % QDEPTH;
         q_count--;
         retired++;
      end
      r.retired_count = retired[4:0];
      if (it.seg_seq == rcv_nxt) begin
         if (it.payload_length != 0) begin
            rcv_nxt = rcv_nxt + it.payload_length;
            r.deliver_payload = 1'b1;
         end
         if (it.seg_flags[FL_FIN_BIT]) rcv_nxt = rcv_nxt + 1;
         if (it.seg_flags[FL_FIN_BIT] || it.payload_length != 0) begin
            r.reply_valid = 1'b1;
            r.reply_flags = FL_ACK;
            r.reply_seq   = it.local_seq;
            r.reply_ack   = rcv_nxt;
         end
      end else begin
         r.drop_code = DROP_OUT_OF_ORD;
      end
   endfunction

   // Full prediction of one item.
   function automatic seg_result_type predict_result(input seg_item_type it);
      seg_result_type r;
      logic        fin_ok;
      r = '{default: '0};
      fin_ok = (it.seg_seq == rcv_nxt) && it.seg_flags[FL_FIN_BIT];
      if (it.operation == OP_RECV) begin
         case (conn_st)
            CS_CLOSE_WAIT, CS_CLOSED, CS_TERMINATED, CS_FREED: begin
               r.drop_code = DROP_BAD_STATE;
            end
            CS_LISTEN: begin
               if (it.seg_flags != FL_SYN) r.drop_code = DROP_NOT_SYN;
               else begin
                  rcv_nxt = it.seg_seq + 1;
                  r.reply_valid = 1'b1;
                  r.reply_flags = FL_SYN_ACK;
                  r.reply_seq = it.local_seq - 1;
                  r.reply_ack = rcv_nxt;
                  conn_st = CS_SYN_RCVD;
               end
            end
            CS_SYN_SENT: begin
               if (it.seg_flags == FL_SYN) begin
                  rcv_nxt = it.seg_seq + 1;
                  r.reply_valid = 1'b1;
                  r.reply_flags = FL_ACK;
                  r.reply_seq = it.local_seq;
                  r.reply_ack = rcv_nxt;
                  conn_st = CS_SYN_RCVD;
               end else if (it.seg_flags == FL_SYN_ACK) begin
                  if (it.seg_ack != it.local_seq) r.drop_code = DROP_SYNACK_ACK;
                  else begin
                     rcv_nxt = it.seg_seq + 1;
                     r.reply_valid = 1'b1;
                     r.reply_flags = FL_ACK;
                     r.reply_seq = it.local_seq;
                     r.reply_ack = rcv_nxt;
                     conn_st = CS_ESTAB;
                     r.wake_socket = 1'b1;
                  end
               end else begin
                  r.drop_code = DROP_SS_FLAGS;
               end
            end
            CS_SYN_RCVD: begin
               if (it.seg_flags == FL_SYN) begin
                  rcv_nxt = it.seg_seq + 1;
                  r.reply_valid = 1'b1;
                  r.reply_flags = FL_SYN_ACK;
                  r.reply_seq = it.local_seq - 1;
                  r.reply_ack = rcv_nxt;
                  conn_st = CS_SYN_RCVD;
               end else if (!it.seg_flags[FL_ACK_BIT] || it.seg_ack != it.local_seq) begin
                  r.drop_code = DROP_NO_ACK;
               end else if (it.seg_seq != rcv_nxt) begin
                  r.drop_code = DROP_WRONG_SEQ;
               end else begin
                  conn_st = CS_ESTAB;
                  r.wake_socket = 1'b1;
                  predict_data_segment(r, it);
               end
            end
            CS_ESTAB: begin
               if (fin_ok) begin
                  conn_st = CS_CLOSE_WAIT;
                  r.wake_socket = 1'b1;
               end
               predict_data_segment(r, it);
            end
            CS_FW1: begin
               if (it.seg_ack == it.local_seq) begin
                  if (fin_ok) begin
                     conn_st = CS_TERMINATED;
                     r.wake_socket = 1'b1;
                  end else conn_st = CS_FW2;
               end else if (fin_ok) begin
                  conn_st = CS_LAST_ACK;
                  r.wake_socket = 1'b1;
               end
               predict_data_segment(r, it);
            end
            CS_FW2: begin
               if (fin_ok) begin
                  conn_st = CS_TERMINATED;
                  r.wake_socket = 1'b1;
               end
               predict_data_segment(r, it);
            end
            CS_LAST_ACK: begin
               if (it.seg_ack == it.local_seq) begin
                  conn_st = CS_TERMINATED;
                  r.wake_socket = 1'b1;
               end else predict_data_segment(r, it);
            end
            default: begin
               r.drop_code = DROP_UNKNOWN;
            end
         endcase
         if (it.seg_flags[FL_RST_BIT]) begin
            conn_st = CS_TERMINATED;
            r.reset_kill = 1'b1;
         end
      end else if (it.operation == OP_SENT) begin
         if (q_count >= QDEPTH) r.queue_full = 1'b1;
         else begin
            sent_ends[q_tail] = {1'b0, it.sent_start} + {17'd0, it.sent_length};
            q_tail = (q_tail + 1) % QDEPTH;
            q_count++;
         end
      end else if (it.operation == OP_FORCE) begin
         conn_st = it.forced_state;
      end
      r.conn_state_out = conn_st;
      return r;
   endfunction

   // Random idle burst, about one time in four; valid is low meanwhile.
   task automatic idle_gap();
      if (!no_idle && $urandom_range(3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
   endtask

   // Send one word and queue its prediction at acceptance.
   task automatic send_item(input seg_item_type it);
      idle_gap();
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= it.operation;
      req_chan.seg_seq        <= it.seg_seq;
      req_chan.seg_ack        <= it.seg_ack;
      req_chan.seg_flags      <= it.seg_flags;
      req_chan.payload_length <= it.payload_length;
      req_chan.local_seq      <= it.local_seq;
      req_chan.sent_start     <= it.sent_start;
      req_chan.sent_length    <= it.sent_length;
      req_chan.forced_state   <= it.forced_state;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_result(it));
      item_count++;
      @(negedge clock);
   endtask

   function automatic seg_item_type blank_item(input logic [1:0] op);
      seg_item_type it;
      it.operation = op;
      it.seg_seq = $urandom;
      it.seg_ack = $urandom;
      it.seg_flags = 6'($urandom);
      it.payload_length = 16'($urandom);
      it.local_seq = $urandom;
      it.sent_start = $urandom;
      it.sent_length = 16'($urandom);
      it.forced_state = 4'($urandom);
      return it;
   endfunction

   task automatic send_force(input logic [3:0] st);
      seg_item_type it;
      it = blank_item(OP_FORCE);
      it.forced_state = st;
      send_item(it);
   endtask

   task automatic send_sent(input logic [31:0] start, input logic [15:0] len);
      seg_item_type it;
      it = blank_item(OP_SENT);
      it.sent_start = start;
      it.sent_length = len;
      send_item(it);
   endtask

   task automatic send_seg(input logic [31:0] seq, input logic [31:0] ack,
                           input logic [5:0] flags, input logic [15:0] plen,
                           input logic [31:0] lseq);
      seg_item_type it;
      it = blank_item(OP_RECV);
      it.seg_seq = seq;
      it.seg_ack = ack;
      it.seg_flags = flags;
      it.payload_length = plen;
      it.local_seq = lseq;
      send_item(it);
   endtask

   // Directed: handshakes, queue limits, extremes and odd states.
   task automatic test_directed();
      logic [31:0] ls;
      ls = 32'hFFFF_FFF0;
      send_seg(0, 0, 0, 0, 0);                         // closed state drops
      send_force(CS_LISTEN);
      send_seg(32'hFFFF_FFFF, 0, FL_ACK, 0, ls);       // not a SYN
      send_seg(32'hFFFF_FFFF, 0, FL_SYN, 0, 0);        // SYN, rcv_next wraps
      send_seg(0, 0, FL_ACK, 0, ls);                   // wrong ack
      send_seg(5, 0, FL_ACK, 0, 0);                    // wrong seq
      for (int i = 0; i < QDEPTH + 1; i++) send_sent(32'hFFFF_0000 + i, 16'hFFFF);
      send_seg(0, 0, FL_ACK | 6'd1, 16'hFFFF, 0);      // establish, data and FIN
      send_force(CS_FW1);
      send_seg(0, 32'hFFFF_FFFF, 6'h3F & ~6'd2, 1, 3); // ack<>lseq, FIN, RST
      send_force(CS_FW1);
      send_seg(1, 7, 6'd1, 0, 7);                      // FW1 to FW2, out of order
      send_force(4'd15);
      send_seg(0, 0, 0, 0, 0);                         // unknown state
      send_force(CS_SYN_SENT);
      send_seg(1, 9, FL_SYN_ACK, 0, 8);                // bad synack ack
      send_seg(1, 9, FL_SYN_ACK, 0, 9);
      send_item(blank_item(2'd3));                     // unused operation
   endtask

   // Random connections with random content, plus noise.
   task automatic test_random(input int n);
      logic [31:0] lseq, rseq;
      seg_item_type it;
      for (int i = 0; i < n; i++) begin
         if (i > n - 150) no_idle = 1'b1;
         lseq = $urandom;
         rseq = rcv_nxt;
         case ($urandom_range(9))
            0: send_force(4'($urandom_range(15)));
            1: send_force(4'($urandom_range(7)));
            2: send_sent(lseq - $urandom_range(200), 16'($urandom_range(300)));
            3: send_item(blank_item(2'($urandom_range(3))));
            4: send_seg($urandom, $urandom, FL_SYN, 16'($urandom), lseq);
            5: send_seg(rseq, lseq, FL_SYN_ACK, 0, lseq);
            default: begin
               it = blank_item(OP_RECV);
               it.seg_flags = FL_ACK | ($urandom_range(3) == 0 ? 6'd1 : 6'd0) |
                              ($urandom_range(20) == 0 ? 6'd4 : 6'd0) |
                              ($urandom_range(1) ? 6'd8 : 6'd0) |
                              ($urandom_range(1) ? 6'd32 : 6'd0);
               if ($urandom_range(4) != 0) it.seg_seq = rseq;
               if ($urandom_range(2) != 0) it.seg_ack = it.local_seq;
               if ($urandom_range(2) != 0) it.payload_length = 16'($urandom_range(1500));
               send_item(it);
            end
         endcase
      end
   endtask

   // Result-side stalls in bursts.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!no_idle && $urandom_range(3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(3, 0)) @(negedge clock);
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Result checker.
   initial begin
      seg_result_type e;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               $error("unexpected result word");
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_chan.reply_valid !== e.reply_valid) begin
                  $error("reply_valid exp %0h got %0h", e.reply_valid, rsp_chan.reply_valid);
                  error_count++;
               end
               if (rsp_chan.reply_flags !== e.reply_flags) begin
                  $error("reply_flags exp %0h got %0h", e.reply_flags, rsp_chan.reply_flags);
                  error_count++;
               end
               if (rsp_chan.reply_seq !== e.reply_seq) begin
                  $error("reply_seq exp %0h got %0h", e.reply_seq, rsp_chan.reply_seq);
                  error_count++;
               end
               if (rsp_chan.reply_ack !== e.reply_ack) begin
                  $error("reply_ack exp %0h got %0h", e.reply_ack, rsp_chan.reply_ack);
                  error_count++;
               end
               if (rsp_chan.deliver_payload !== e.deliver_payload) begin
                  $error("deliver_payload exp %0h got %0h", e.deliver_payload,
                         rsp_chan.deliver_payload);
                  error_count++;
               end
               if (rsp_chan.wake_socket !== e.wake_socket) begin
                  $error("wake_socket exp %0h got %0h", e.wake_socket, rsp_chan.wake_socket);
                  error_count++;
               end
               if (rsp_chan.drop_code !== e.drop_code) begin
                  $error("drop_code exp %0h got %0h", e.drop_code, rsp_chan.drop_code);
                  error_count++;
               end
               if (rsp_chan.retired_count !== e.retired_count) begin
                  $error("retired_count exp %0h got %0h", e.retired_count,
                         rsp_chan.retired_count);
                  error_count++;
               end
               if (rsp_chan.reset_kill !== e.reset_kill) begin
                  $error("reset_kill exp %0h got %0h", e.reset_kill, rsp_chan.reset_kill);
                  error_count++;
               end
               if (rsp_chan.queue_full !== e.queue_full) begin
                  $error("queue_full exp %0h got %0h", e.queue_full, rsp_chan.queue_full);
                  error_count++;
               end
               if (rsp_chan.conn_state_out !== e.conn_state_out) begin
                  $error("conn_state_out exp %0h got %0h", e.conn_state_out,
                         rsp_chan.conn_state_out);
                  error_count++;
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin
      int waited;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_RECV;
      req_chan.seg_seq = '0;
      req_chan.seg_ack = '0;
      req_chan.seg_flags = '0;
      req_chan.payload_length = '0;
      req_chan.local_seq = '0;
      req_chan.sent_start = '0;
      req_chan.sent_length = '0;
      req_chan.forced_state = '0;
      conn_st = CS_CLOSED;
      rcv_nxt = '0;
      q_head = 0;
      q_tail = 0;
      q_count = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1780);
      req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      $display("Sent %0d words and checked %0d results across all connection states,",
               item_count, result_count);
      $display("including handshakes, sent-queue retirement, full queue and resets.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== tcp_receive_state_machine_core.f =====
rtl/tcprx_pkg.sv
rtl/tcprx_req_if.sv
rtl/tcprx_rsp_if.sv
rtl/tcprx_ram.sv
rtl/tcp_receive_state_machine_core.sv
sim/tb.sv
